// File: rtl/lld_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the least-loaded worker dispatcher
// no dependencies; imported by every module of the block
package lld_pkg;

    localparam int ID_W   = 16;
    localparam int LOAD_W = 7;
    localparam int COOK_W = 6;
    localparam int OP_W   = 2;
    localparam int TAG_W  = 4;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OP_W-1:0] OP_EXIT     = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

    localparam logic [COOK_W-1:0] COOK_RESET = 6'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } t_state;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_INC,
        UPD_DEC,
        UPD_OPEN,
        UPD_CLEAR
    } t_upd_kind;

    // slot update broadcast to the row of cells
    typedef struct packed {
        t_upd_kind        kind;
        logic [ID_W-1:0]  id;
    } t_upd;

    // item context seen by every cell during a scan
    typedef struct packed {
        logic [ID_W-1:0]   wid;
        logic [LOAD_W-1:0] cap;
    } t_scan;

    // running search result handed from cell to cell
    typedef struct packed {
        logic              best_valid;
        logic [LOAD_W-1:0] best_load;
        logic [ID_W-1:0]   best_id;
        logic              any_match;
        logic              ml_valid;
        logic              free_valid;
    } t_probe;

    localparam t_probe PROBE_INIT = '{
        best_valid: 1'b0,
        best_load:  '0,
        best_id:    '0,
        any_match:  1'b0,
        ml_valid:   1'b0,
        free_valid: 1'b0
    };

endpackage

// File: rtl/lld_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: request, result and configuration write
// widths follow the field widths in lld_pkg
interface lld_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] worker_id;
    logic [3:0]  job_kind;
    logic [3:0]  job_size;

    modport source (output valid, operation, worker_id, job_kind, job_size, input ready);
    modport sink   (input valid, operation, worker_id, job_kind, job_size, output ready);
endinterface

interface lld_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] assigned_id;
    logic        new_worker;
    logic [1:0]  status;
    logic [3:0]  out_kind;
    logic [3:0]  out_size;

    modport source (output valid, assigned_id, new_worker, status, out_kind, out_size,
                    input ready);
    modport sink   (input valid, assigned_id, new_worker, status, out_kind, out_size,
                    output ready);
endinterface

interface lld_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/lld_cell.sv
`timescale 1ns / 1ps
// one worker slot of the row: holds valid, id and job count, and folds
// itself into the search word passed to its neighbor; uses lld_pkg
module lld_cell
    import lld_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_scan         i_scan,
    input  t_probe        i_probe,
    input  logic [IW-1:0] i_best_idx,
    input  logic [IW-1:0] i_match_idx,
    input  logic [IW-1:0] i_ml_idx,
    input  logic [IW-1:0] i_free_idx,
    input  t_upd          i_upd,
    input  logic [IW-1:0] i_upd_idx,
    output t_probe        o_probe,
    output logic [IW-1:0] o_best_idx,
    output logic [IW-1:0] o_match_idx,
    output logic [IW-1:0] o_ml_idx,
    output logic [IW-1:0] o_free_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [LOAD_W-1:0] r_load;

    t_probe        n_probe;
    logic [IW-1:0] n_best_idx;
    logic [IW-1:0] n_match_idx;
    logic [IW-1:0] n_ml_idx;
    logic [IW-1:0] n_free_idx;
    t_probe        r_probe;
    logic [IW-1:0] r_best_idx;
    logic [IW-1:0] r_match_idx;
    logic [IW-1:0] r_ml_idx;
    logic [IW-1:0] r_free_idx;

    logic w_hit;
    logic w_elig;
    logic w_better;
    logic w_match;

    assign w_hit   = (i_upd_idx == MY_IDX);
    assign w_elig  = r_valid && (r_load < i_scan.cap);
    assign w_match = r_valid && (r_id == i_scan.wid);
    assign w_better = w_elig && (!i_probe.best_valid || (r_load < i_probe.best_load) ||
                      ((r_load == i_probe.best_load) && (r_id < i_probe.best_id)));

    // fold this slot into the search word
    always_comb begin
        n_probe     = i_probe;
        n_best_idx  = i_best_idx;
        n_match_idx = i_match_idx;
        n_ml_idx    = i_ml_idx;
        n_free_idx  = i_free_idx;
        if (w_better) begin
            n_probe.best_valid = 1'b1;
            n_probe.best_load  = r_load;
            n_probe.best_id    = r_id;
            n_best_idx         = MY_IDX;
        end
        if (w_match && !i_probe.any_match) begin
            n_probe.any_match = 1'b1;
            n_match_idx       = MY_IDX;
        end
        if (w_match && (r_load != '0) && !i_probe.ml_valid) begin
            n_probe.ml_valid = 1'b1;
            n_ml_idx         = MY_IDX;
        end
        if (!r_valid && !i_probe.free_valid) begin
            n_probe.free_valid = 1'b1;
            n_free_idx         = MY_IDX;
        end
    end

    // search word to the neighbor
    always_ff @(posedge i_clk) begin
        r_probe     <= n_probe;
        r_best_idx  <= n_best_idx;
        r_match_idx <= n_match_idx;
        r_ml_idx    <= n_ml_idx;
        r_free_idx  <= n_free_idx;
    end

    // slot valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_hit && (i_upd.kind == UPD_OPEN)) begin
            r_valid <= 1'b1;
        end else if (w_hit && (i_upd.kind == UPD_CLEAR)) begin
            r_valid <= 1'b0;
        end
    end

    // slot id and job count
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            unique case (i_upd.kind)
                UPD_INC: r_load <= r_load + LOAD_W'(1);
                UPD_DEC: r_load <= r_load - LOAD_W'(1);
                UPD_OPEN: begin
                    r_id   <= i_upd.id;
                    r_load <= LOAD_W'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_probe     = r_probe;
    assign o_best_idx  = r_best_idx;
    assign o_match_idx = r_match_idx;
    assign o_ml_idx    = r_ml_idx;
    assign o_free_idx  = r_free_idx;

endmodule

// File: rtl/lld_ctrl.sv
`timescale 1ns / 1ps
// sequencer: takes a request, waits for the search word to cross the row,
// decides the slot update and fills the result register; uses lld_pkg, lld_ifs
module lld_ctrl
    import lld_pkg::*;
#(
    parameter int MAX_WORKERS = 16,
    parameter int IW          = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lld_in_if.sink        i_in,
    lld_out_if.source     o_out,
    lld_cfg_if.sink       i_cfg,
    output t_scan         o_scan,
    input  t_probe        i_probe,
    input  logic [IW-1:0] i_best_idx,
    input  logic [IW-1:0] i_match_idx,
    input  logic [IW-1:0] i_ml_idx,
    input  logic [IW-1:0] i_free_idx,
    output t_upd          o_upd,
    output logic [IW-1:0] o_upd_idx
);

    localparam logic [IW-1:0] LAST = IW'(MAX_WORKERS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [IW-1:0]     r_cnt;
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_wid;
    logic [TAG_W-1:0]  r_kind;
    logic [TAG_W-1:0]  r_size;
    logic [COOK_W-1:0] r_cook;
    logic [ID_W-1:0]   r_last_id;

    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_new;
    logic [STAT_W-1:0] r_out_status;
    logic [TAG_W-1:0]  r_out_kind;
    logic [TAG_W-1:0]  r_out_size;

    logic              w_accept;
    logic              w_out_free;
    logic              w_fire;
    t_upd_kind         d_kind;
    logic [IW-1:0]     d_idx;
    logic [ID_W-1:0]   d_id;
    logic              d_new;
    logic [STAT_W-1:0] d_status;
    logic [TAG_W-1:0]  d_okind;
    logic [TAG_W-1:0]  d_osize;
    logic [ID_W-1:0]   w_next_id;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_fire     = (r_state == S_RESOLVE) && w_out_free;
    assign w_next_id  = r_last_id + ID_W'(1);
    assign i_cfg.ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in.valid) n_state = S_SCAN;
            S_SCAN:    if (r_cnt == LAST) n_state = S_RESOLVE;
            S_RESOLVE: if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready    = (r_state == S_IDLE);
        o_upd.kind    = w_fire ? d_kind : UPD_NONE;
        o_upd.id      = w_next_id;
        o_upd_idx     = d_idx;
    end

    assign o_scan.wid = r_wid;
    assign o_scan.cap = {r_cook, 1'b0};

    // decision from the search word that left the row
    always_comb begin
        d_kind   = UPD_NONE;
        d_idx    = i_best_idx;
        d_id     = r_wid;
        d_new    = 1'b0;
        d_status = ST_DONE;
        d_okind  = '0;
        d_osize  = '0;
        unique case (r_op)
            OP_DISPATCH: begin
                d_okind = r_kind;
                d_osize = r_size;
                priority if (i_probe.best_valid) begin
                    d_kind = UPD_INC;
                    d_idx  = i_best_idx;
                    d_id   = i_probe.best_id;
                end else if (i_probe.free_valid) begin
                    d_kind = UPD_OPEN;
                    d_idx  = i_free_idx;
                    d_id   = w_next_id;
                    d_new  = 1'b1;
                end else begin
                    d_status = ST_FULL;
                end
            end
            OP_COMPLETE: begin
                priority if (!i_probe.any_match) begin
                    d_status = ST_UNKNOWN;
                end else if (i_probe.ml_valid) begin
                    d_kind = UPD_DEC;
                    d_idx  = i_ml_idx;
                end else begin
                    d_kind = UPD_NONE;
                end
            end
            OP_EXIT: begin
                if (!i_probe.any_match) begin
                    d_status = ST_UNKNOWN;
                end else begin
                    d_kind = UPD_CLEAR;
                    d_idx  = i_match_idx;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cook      <= COOK_RESET;
            r_last_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + IW'(1);
            end
            if (i_cfg.valid) begin
                r_cook <= i_cfg.data;
            end
            if (w_fire && (d_kind == UPD_OPEN)) begin
                r_last_id <= w_next_id;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request word and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_in.operation;
            r_wid  <= i_in.worker_id;
            r_kind <= i_in.job_kind;
            r_size <= i_in.job_size;
        end
        if (w_fire) begin
            r_out_id     <= d_id;
            r_out_new    <= d_new;
            r_out_status <= d_status;
            r_out_kind   <= d_okind;
            r_out_size   <= d_osize;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.assigned_id = r_out_id;
    assign o_out.new_worker  = r_out_new;
    assign o_out.status      = r_out_status;
    assign o_out.out_kind    = r_out_kind;
    assign o_out.out_size    = r_out_size;

endmodule

// File: rtl/least_loaded_worker_dispatcher.sv
`timescale 1ns / 1ps
// least-loaded worker dispatcher: sequencer plus a row of slot cells
// depends on lld_pkg, lld_ifs, lld_cell, lld_ctrl
//
//  channel  dir  word                                              handshake
//  i_in     in   operation, worker_id, job_kind, job_size          valid/ready
//  o_out    out  assigned_id, new_worker, status, out_kind, size   valid/ready
//  i_cfg    in   data = cook_count                                 valid/ready
//
// an item is accepted in the idle step; the search word then walks the row,
// registered in each cell in turn; the resolve step decides and applies the update;
// the result register lets the next word be accepted while a result waits;
// a stalled result holds the sequencer in its resolve step
// reset clears the slot valid bits, the id counter and sets cook_count to 4
module least_loaded_worker_dispatcher
    import lld_pkg::*;
#(
    parameter int MAX_WORKERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lld_in_if.sink    i_in,
    lld_out_if.source o_out,
    lld_cfg_if.sink   i_cfg
);

    localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    t_scan         w_scan;
    t_upd          w_upd;
    logic [IW-1:0] w_upd_idx;
    t_probe        w_probe     [MAX_WORKERS+1];
    logic [IW-1:0] w_best_idx  [MAX_WORKERS+1];
    logic [IW-1:0] w_match_idx [MAX_WORKERS+1];
    logic [IW-1:0] w_ml_idx    [MAX_WORKERS+1];
    logic [IW-1:0] w_free_idx  [MAX_WORKERS+1];

    // empty search word enters the first cell
    assign w_probe[0]     = PROBE_INIT;
    assign w_best_idx[0]  = '0;
    assign w_match_idx[0] = '0;
    assign w_ml_idx[0]    = '0;
    assign w_free_idx[0]  = '0;

    lld_ctrl #(
        .MAX_WORKERS (MAX_WORKERS),
        .IW          (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg       (i_cfg),
        .o_scan      (w_scan),
        .i_probe     (w_probe[MAX_WORKERS]),
        .i_best_idx  (w_best_idx[MAX_WORKERS]),
        .i_match_idx (w_match_idx[MAX_WORKERS]),
        .i_ml_idx    (w_ml_idx[MAX_WORKERS]),
        .i_free_idx  (w_free_idx[MAX_WORKERS]),
        .o_upd       (w_upd),
        .o_upd_idx   (w_upd_idx)
    );

    // row of slot cells
    for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_cell
        lld_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_scan      (w_scan),
            .i_probe     (w_probe[g]),
            .i_best_idx  (w_best_idx[g]),
            .i_match_idx (w_match_idx[g]),
            .i_ml_idx    (w_ml_idx[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_upd       (w_upd),
            .i_upd_idx   (w_upd_idx),
            .o_probe     (w_probe[g+1]),
            .o_best_idx  (w_best_idx[g+1]),
            .o_match_idx (w_match_idx[g+1]),
            .o_ml_idx    (w_ml_idx[g+1]),
            .o_free_idx  (w_free_idx[g+1])
        );
    end

endmodule

// File: sim/lld_checker.sv
`timescale 1ns / 1ps
// result checker for the least-loaded worker dispatcher: watches all three channels
// depends on lld_pkg and lld_ifs; keeps its own copy of the slot table and cook count
module lld_checker
    import lld_pkg::*;
#(
    parameter int MAX_WORKERS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lld_in_if     i_in,
    lld_out_if    i_out,
    lld_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_result_count,
    output int    o_pending,
    output logic [ID_W-1:0] o_newest_id,
    output int    o_new_count,
    output int    o_full_count,
    output int    o_unknown_count
);

    // one result word as the block should answer it
    typedef struct packed {
        logic [ID_W-1:0]   assigned_id;
        logic              new_worker;
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  kind;
        logic [TAG_W-1:0]  size;
    } t_assignment;

    localparam int MAX_REPORTS = 40;

    // mirror of the worker table
    logic              live      [MAX_WORKERS];
    logic [ID_W-1:0]   worker_id [MAX_WORKERS];
    logic [LOAD_W-1:0] job_count [MAX_WORKERS];
    logic [ID_W-1:0]   newest_id;
    logic [COOK_W-1:0] cooks;

    t_assignment expected_q [$];
    t_assignment want;
    t_assignment got;

    int fail_count    = 0;
    int result_count  = 0;
    int new_count     = 0;
    int full_count    = 0;
    int unknown_count = 0;

    // apply one request word to the table, return the answer it should get
    function automatic t_assignment predict_assignment(
        logic [OP_W-1:0]  op,
        logic [ID_W-1:0]  wid,
        logic [TAG_W-1:0] kind,
        logic [TAG_W-1:0] size
    );
        t_assignment       ans;
        logic [LOAD_W-1:0] cap;
        int                best;
        int                free_slot;
        int                hit;
        logic              known;

        ans = '0;
        ans.assigned_id = wid;
        best = -1;
        free_slot = -1;
        hit = -1;
        known = 1'b0;
        case (op)
            OP_DISPATCH: begin
                ans.kind = kind;
                ans.size = size;
                cap = {1'b0, cooks} << 1;
                // least loaded worker with room, lowest id on a tie
                for (int i = 0; i < MAX_WORKERS; i++) begin
                    if (live[i] && job_count[i] < cap) begin
                        if (best < 0 || job_count[i] < job_count[best] ||
                            (job_count[i] == job_count[best] && worker_id[i] < worker_id[best]))
                            best = i;
                    end
                end
                if (best >= 0) begin
                    job_count[best] = job_count[best] + 1'b1;
                    ans.assigned_id = worker_id[best];
                end else begin
                    for (int i = 0; i < MAX_WORKERS; i++)
                        if (!live[i] && free_slot < 0)
                            free_slot = i;
                    if (free_slot < 0) begin
                        ans.status = ST_FULL;
                    end else begin
                        // open a new worker in the lowest free slot
                        newest_id = newest_id + 1'b1;
                        live[free_slot] = 1'b1;
                        worker_id[free_slot] = newest_id;
                        job_count[free_slot] = LOAD_W'(1);
                        ans.assigned_id = newest_id;
                        ans.new_worker = 1'b1;
                    end
                end
            end
            OP_COMPLETE: begin
                for (int i = 0; i < MAX_WORKERS; i++) begin
                    if (live[i] && worker_id[i] == wid) begin
                        known = 1'b1;
                        if (job_count[i] != 0 && hit < 0)
                            hit = i;
                    end
                end
                if (!known)
                    ans.status = ST_UNKNOWN;
                else if (hit >= 0)
                    job_count[hit] = job_count[hit] - 1'b1;
            end
            OP_EXIT: begin
                for (int i = 0; i < MAX_WORKERS; i++)
                    if (live[i] && worker_id[i] == wid && hit < 0)
                        hit = i;
                if (hit < 0)
                    ans.status = ST_UNKNOWN;
                else
                    live[hit] = 1'b0;
            end
            default: begin
                // reserved code: echo only
            end
        endcase
        return ans;
    endfunction

    task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_val, act_val);
        end
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WORKERS; i++)
                live[i] = 1'b0;
            newest_id = '0;
            cooks = COOK_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                cooks = i_cfg.data;

            if (i_out.valid && i_out.ready) begin
                result_count++;
                got.assigned_id = i_out.assigned_id;
                got.new_worker  = i_out.new_worker;
                got.status      = i_out.status;
                got.kind        = i_out.out_kind;
                got.size        = i_out.out_size;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result word, expected none, actual %h",
                                 $time, got);
                end else begin
                    want = expected_q.pop_front();
                    check_field("assigned_id", want.assigned_id, got.assigned_id);
                    check_field("new_worker", want.new_worker, got.new_worker);
                    check_field("status", want.status, got.status);
                    check_field("out_kind", want.kind, got.kind);
                    check_field("out_size", want.size, got.size);
                end
            end

            if (i_in.valid && i_in.ready) begin
                want = predict_assignment(i_in.operation, i_in.worker_id,
                                          i_in.job_kind, i_in.job_size);
                if (want.new_worker)
                    new_count++;
                if (want.status == ST_FULL)
                    full_count++;
                if (want.status == ST_UNKNOWN)
                    unknown_count++;
                expected_q.insert(expected_q.size(), want);
            end
        end

        o_fail_count    <= fail_count;
        o_result_count  <= result_count;
        o_pending       <= expected_q.size();
        o_newest_id     <= newest_id;
        o_new_count     <= new_count;
        o_full_count    <= full_count;
        o_unknown_count <= unknown_count;
    end

endmodule

// File: sim/least_loaded_worker_dispatcher_tb.sv
`timescale 1ns / 1ps
// testbench top for the least-loaded worker dispatcher: clock, reset, stimulus, verdict
// depends on lld_pkg, lld_ifs, lld_checker and the block itself
module least_loaded_worker_dispatcher_tb;
    import lld_pkg::*;

    localparam int MAX_WORKERS    = 16;
    localparam int N_PHASES       = 7;
    localparam int N_RANDOM       = 230;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = MAX_WORKERS + 4;

    // code 3 has no meaning in the block; it must answer without side effects
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    lld_in_if  in_ch ();
    lld_out_if out_ch ();
    lld_cfg_if cfg_ch ();

    int              fail_count;
    int              result_count;
    int              pending;
    logic [ID_W-1:0] newest_id;
    int              new_count;
    int              full_count;
    int              unknown_count;

    int          n_sent     = 0;
    int          n_settings = 0;
    int unsigned send_idle  = 13;
    int unsigned recv_idle  = 63;
    int          quiet      = 0;

    least_loaded_worker_dispatcher #(
        .MAX_WORKERS(MAX_WORKERS)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lld_checker #(
        .MAX_WORKERS(MAX_WORKERS)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .i_cfg           (cfg_ch),
        .o_fail_count    (fail_count),
        .o_result_count  (result_count),
        .o_pending       (pending),
        .o_newest_id     (newest_id),
        .o_new_count     (new_count),
        .o_full_count    (full_count),
        .o_unknown_count (unknown_count)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk) begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // present one request word, with an optional gap before it
    task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] wid,
                             logic [TAG_W-1:0] kind, logic [TAG_W-1:0] size);
        if ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.worker_id <= wid;
        in_ch.job_kind  <= kind;
        in_ch.job_size  <= size;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (result_count < n_sent)
            @(posedge clk);
    endtask

    // cook count is only changed with nothing in flight
    task automatic write_cook(logic [COOK_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // dispatches, plus completions and exits that name recently opened workers, some noise
    task automatic send_random();
        int unsigned     pick;
        logic [ID_W-1:0] wid;

        pick = $urandom_range(99);
        wid = newest_id - ID_W'($urandom_range(17));
        if (pick < 48)
            send_word(OP_DISPATCH, ID_W'($urandom()), TAG_W'($urandom_range(15)),
                      TAG_W'($urandom_range(15)));
        else if (pick < 78)
            send_word(OP_COMPLETE, wid, TAG_W'($urandom_range(15)),
                      TAG_W'($urandom_range(15)));
        else if (pick < 90)
            send_word(OP_EXIT, wid, TAG_W'($urandom_range(15)), TAG_W'($urandom_range(15)));
        else
            send_word(OP_W'($urandom_range(3)), ID_W'($urandom()),
                      TAG_W'($urandom_range(15)), TAG_W'($urandom_range(15)));
    endtask

    initial begin
        logic [COOK_W-1:0] cook_plan [N_PHASES];

        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_DISPATCH;
        in_ch.worker_id  <= '0;
        in_ch.job_kind   <= '0;
        in_ch.job_size   <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, reset cook count: unknown ids, reserved code, one worker's life
        send_word(OP_COMPLETE, 16'd5, 4'h0, 4'h0);
        send_word(OP_EXIT, 16'hFFFF, 4'hF, 4'hF);
        send_word(OP_RESERVED, 16'hFFFF, 4'hF, 4'hF);
        send_word(OP_DISPATCH, 16'hFFFF, 4'h0, 4'h0);
        send_word(OP_DISPATCH, 16'h0000, 4'hF, 4'hF);
        send_word(OP_COMPLETE, 16'd1, 4'h0, 4'h0);
        send_word(OP_COMPLETE, 16'd1, 4'h0, 4'h0);
        // completion at zero load, then exit and a completion of the gone worker
        send_word(OP_COMPLETE, 16'd1, 4'h0, 4'h0);
        send_word(OP_EXIT, 16'd1, 4'h0, 4'h0);
        send_word(OP_COMPLETE, 16'd1, 4'h0, 4'h0);

        // zero capacity: every dispatch opens a worker until the table is full
        write_cook('0);
        for (int i = 0; i < MAX_WORKERS; i++)
            send_word(OP_DISPATCH, ID_W'($urandom()), TAG_W'(i), TAG_W'(15 - i));
        send_word(OP_DISPATCH, 16'hA5A5, 4'h5, 4'hA);
        send_word(OP_EXIT, 16'd9, 4'h0, 4'h0);
        send_word(OP_DISPATCH, 16'h5A5A, 4'hA, 4'h5);

        cook_plan[0] = 6'd1;
        cook_plan[1] = 6'd63;
        cook_plan[2] = 6'd32;
        cook_plan[3] = 6'd2;
        cook_plan[4] = COOK_W'($urandom_range(63));
        cook_plan[5] = 6'd3;
        cook_plan[6] = COOK_W'($urandom_range(1, 32));

        // random phases, one cook count each, idling pattern changing along the way
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                send_idle = 63;
                recv_idle = 13;
            end
            if (p == 5) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_cook(cook_plan[p]);
            repeat (N_RANDOM)
                send_random();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests under %0d cook count settings plus the reset one",
                 n_sent, n_settings);
        $display("%0d workers opened, %0d rejected dispatches, %0d unknown ids",
                 new_count, full_count, unknown_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/lld_pkg.sv
rtl/lld_ifs.sv
rtl/lld_cell.sv
rtl/lld_ctrl.sv
rtl/least_loaded_worker_dispatcher.sv
sim/lld_checker.sv
sim/least_loaded_worker_dispatcher_tb.sv
